// ===== design/pp2rgb_pkg.sv =====
// pixel pair to rgb24 converter: shared widths, format and register codes,
// matrix coefficients and the structs passed between pipeline stages
// no dependencies
`timescale 1ns / 1ps

package pp2rgb_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned WordW    = 64;
   localparam int unsigned NumBytes = WordW / ByteW;
   localparam int unsigned FmtW     = 4;
   localparam int unsigned CsrIdxW  = 2;
   localparam int unsigned CsrDataW = 4;
   localparam int unsigned FracW    = 16;
   localparam int unsigned CoefW    = 19;
   localparam int unsigned SdW      = ByteW + 1;
   localparam int unsigned MulW     = CoefW + SdW;
   localparam int unsigned ProdW    = 26;
   localparam int unsigned SumW     = 27;

   typedef enum logic [FmtW-1:0] {
      FMT_RGB565    = 4'd0,
      FMT_RGB565X   = 4'd1,
      FMT_YUYV      = 4'd2,
      FMT_UYVY      = 4'd3,
      FMT_YVYU      = 4'd4,
      FMT_VYUY      = 4'd5,
      FMT_SEMI_UV   = 4'd6,
      FMT_SEMI_VU   = 4'd7,
      FMT_PLANAR_UV = 4'd8,
      FMT_PLANAR_VU = 4'd9,
      FMT_XRGB32    = 4'd10,
      FMT_XBGR32    = 4'd11,
      FMT_BGR24     = 4'd12
   } pix_fmt_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PIXEL_FORMAT  = 2'd0,
      CSR_MATRIX_SELECT = 2'd1,
      CSR_FULL_RANGE    = 2'd2
   } csr_idx_type;

   localparam logic MATRIX_BT601 = 1'b0;

   localparam logic signed [SdW-1:0]   LUMA_OFFSET = 9'sd16;
   localparam logic signed [SdW-1:0]   CHROMA_BIAS = 9'sd128;
   localparam logic signed [CoefW-1:0] LUMA_GAIN   = 19'sd76284;

   localparam logic signed [CoefW-1:0] R_V_601 = 19'sd104595;
   localparam logic signed [CoefW-1:0] G_U_601 = -19'sd25690;
   localparam logic signed [CoefW-1:0] G_V_601 = -19'sd53281;
   localparam logic signed [CoefW-1:0] B_U_601 = 19'sd132186;
   localparam logic signed [CoefW-1:0] R_V_709 = 19'sd117506;
   localparam logic signed [CoefW-1:0] G_U_709 = -19'sd13959;
   localparam logic signed [CoefW-1:0] G_V_709 = -19'sd34931;
   localparam logic signed [CoefW-1:0] B_U_709 = 19'sd138412;

   typedef struct packed {
      logic [FmtW-1:0] pixel_format;
      logic            matrix_select;
      logic            full_range;
   } csr_type;

   typedef struct packed {
      logic [ByteW-1:0] red_left;
      logic [ByteW-1:0] green_left;
      logic [ByteW-1:0] blue_left;
      logic [ByteW-1:0] red_right;
      logic [ByteW-1:0] green_right;
      logic [ByteW-1:0] blue_right;
   } rgb_pair_type;

   typedef struct packed {
      logic             is_yuv;
      logic [ByteW-1:0] luma_left;
      logic [ByteW-1:0] luma_right;
      logic [ByteW-1:0] chroma_u;
      logic [ByteW-1:0] chroma_v;
      rgb_pair_type     direct;
   } unpack_type;

   typedef struct packed {
      logic                    is_yuv;
      logic signed [ProdW-1:0] luma_left;
      logic signed [ProdW-1:0] luma_right;
      logic signed [ProdW-1:0] red_v;
      logic signed [ProdW-1:0] green_u;
      logic signed [ProdW-1:0] green_v;
      logic signed [ProdW-1:0] blue_u;
      rgb_pair_type            direct;
   } prod_type;

endpackage

// ===== design/pp2rgb_unpack.sv =====
// pixel pair to rgb24 converter: byte unpacking per source format
// picks luma and chroma for yuv sources, expands or reorders rgb sources
// depends on pp2rgb_pkg
`timescale 1ns / 1ps

module pp2rgb_unpack (
   input  logic [pp2rgb_pkg::WordW-1:0] packed_bytes,
   input  logic [pp2rgb_pkg::ByteW-1:0] chroma_first,
   input  logic [pp2rgb_pkg::ByteW-1:0] chroma_second,
   input  logic [pp2rgb_pkg::FmtW-1:0]  pixel_format,
   output pp2rgb_pkg::unpack_type       unpacked
);
   import pp2rgb_pkg::*;

   logic [ByteW-1:0]   b [NumBytes];
   logic [2*ByteW-1:0] pix_left;
   logic [2*ByteW-1:0] pix_right;
   logic [3*ByteW-1:0] exp_left;
   logic [3*ByteW-1:0] exp_right;

   function automatic logic [3*ByteW-1:0] expand_565(input logic [2*ByteW-1:0] pix);
      return {pix[15:11], 3'b111, pix[10:5], 2'b11, pix[4:0], 3'b111};
   endfunction

   for (genvar k = 0; k < NumBytes; k++) begin : g_bytes
      assign b[k] = packed_bytes[k*ByteW +: ByteW];
   end

   // byte-swapped variant takes the odd byte as high half
   assign pix_left  = (pixel_format == FMT_RGB565) ? {b[0], b[1]} : {b[1], b[0]};
   assign pix_right = (pixel_format == FMT_RGB565) ? {b[2], b[3]} : {b[3], b[2]};
   assign exp_left  = expand_565(pix_left);
   assign exp_right = expand_565(pix_right);

   always_comb begin
      unpacked = '0;
      unique case (pixel_format) inside
         FMT_RGB565, FMT_RGB565X: begin
            unpacked.direct = {exp_left, exp_right};
         end
         FMT_YUYV: begin
            unpacked.is_yuv     = 1'b1;
            unpacked.luma_left  = b[0];
            unpacked.luma_right = b[2];
            unpacked.chroma_u   = b[1];
            unpacked.chroma_v   = b[3];
         end
         FMT_UYVY: begin
            unpacked.is_yuv     = 1'b1;
            unpacked.luma_left  = b[1];
            unpacked.luma_right = b[3];
            unpacked.chroma_u   = b[0];
            unpacked.chroma_v   = b[2];
         end
         FMT_YVYU: begin
            unpacked.is_yuv     = 1'b1;
            unpacked.luma_left  = b[0];
            unpacked.luma_right = b[2];
            unpacked.chroma_u   = b[3];
            unpacked.chroma_v   = b[1];
         end
         FMT_VYUY: begin
            unpacked.is_yuv     = 1'b1;
            unpacked.luma_left  = b[1];
            unpacked.luma_right = b[3];
            unpacked.chroma_u   = b[2];
            unpacked.chroma_v   = b[0];
         end
         FMT_SEMI_UV, FMT_PLANAR_UV: begin
            unpacked.is_yuv     = 1'b1;
            unpacked.luma_left  = b[0];
            unpacked.luma_right = b[1];
            unpacked.chroma_u   = chroma_first;
            unpacked.chroma_v   = chroma_second;
         end
         FMT_SEMI_VU, FMT_PLANAR_VU: begin
            unpacked.is_yuv     = 1'b1;
            unpacked.luma_left  = b[0];
            unpacked.luma_right = b[1];
            unpacked.chroma_u   = chroma_second;
            unpacked.chroma_v   = chroma_first;
         end
         FMT_XRGB32: begin
            unpacked.direct = {b[1], b[2], b[3], b[5], b[6], b[7]};
         end
         FMT_XBGR32: begin
            unpacked.direct = {b[2], b[1], b[0], b[6], b[5], b[4]};
         end
         // bgr24, also the unassigned codes
         default: begin
            unpacked.direct = {b[2], b[1], b[0], b[5], b[4], b[3]};
         end
      endcase
   end

endmodule

// ===== design/pp2rgb_yuv_mult.sv =====
// pixel pair to rgb24 converter: luma scaling and chroma coefficient products
// one multiplier level, bt.601 or bt.709 coefficients, full or limited range
// depends on pp2rgb_pkg
`timescale 1ns / 1ps

module pp2rgb_yuv_mult (
   input  pp2rgb_pkg::unpack_type unpacked,
   input  logic                   matrix_select,
   input  logic                   full_range,
   output pp2rgb_pkg::prod_type   products
);
   import pp2rgb_pkg::*;

   logic signed [SdW-1:0]   yl_s;
   logic signed [SdW-1:0]   yr_s;
   logic signed [SdW-1:0]   u_s;
   logic signed [SdW-1:0]   v_s;
   logic signed [CoefW-1:0] c_rv;
   logic signed [CoefW-1:0] c_gu;
   logic signed [CoefW-1:0] c_gv;
   logic signed [CoefW-1:0] c_bu;
   logic signed [MulW-1:0]  p_yl;
   logic signed [MulW-1:0]  p_yr;
   logic signed [MulW-1:0]  p_rv;
   logic signed [MulW-1:0]  p_gu;
   logic signed [MulW-1:0]  p_gv;
   logic signed [MulW-1:0]  p_bu;
   logic [ProdW-1:0]        full_yl;
   logic [ProdW-1:0]        full_yr;

   assign yl_s = $signed({1'b0, unpacked.luma_left})  - LUMA_OFFSET;
   assign yr_s = $signed({1'b0, unpacked.luma_right}) - LUMA_OFFSET;
   assign u_s  = $signed({1'b0, unpacked.chroma_u})   - CHROMA_BIAS;
   assign v_s  = $signed({1'b0, unpacked.chroma_v})   - CHROMA_BIAS;

   assign c_rv = (matrix_select == MATRIX_BT601) ? R_V_601 : R_V_709;
   assign c_gu = (matrix_select == MATRIX_BT601) ? G_U_601 : G_U_709;
   assign c_gv = (matrix_select == MATRIX_BT601) ? G_V_601 : G_V_709;
   assign c_bu = (matrix_select == MATRIX_BT601) ? B_U_601 : B_U_709;

   assign p_yl = yl_s * LUMA_GAIN;
   assign p_yr = yr_s * LUMA_GAIN;
   assign p_rv = v_s * c_rv;
   assign p_gu = u_s * c_gu;
   assign p_gv = v_s * c_gv;
   assign p_bu = u_s * c_bu;

   // full range: luma times one in 10.16
   assign full_yl = {{(ProdW-ByteW-FracW){1'b0}}, unpacked.luma_left,  {FracW{1'b0}}};
   assign full_yr = {{(ProdW-ByteW-FracW){1'b0}}, unpacked.luma_right, {FracW{1'b0}}};

   always_comb begin
      products.is_yuv     = unpacked.is_yuv;
      products.direct     = unpacked.direct;
      products.luma_left  = full_range ? full_yl : p_yl[ProdW-1:0];
      products.luma_right = full_range ? full_yr : p_yr[ProdW-1:0];
      products.red_v      = p_rv[ProdW-1:0];
      products.green_u    = p_gu[ProdW-1:0];
      products.green_v    = p_gv[ProdW-1:0];
      products.blue_u     = p_bu[ProdW-1:0];
   end

endmodule

// ===== design/pp2rgb_mix.sv =====
// pixel pair to rgb24 converter: matrix sums, clamping and result select
// clamps each 11.16 sum to 0..255, passes rgb sources straight through
// depends on pp2rgb_pkg
`timescale 1ns / 1ps

module pp2rgb_mix (
   input  pp2rgb_pkg::prod_type     products,
   output pp2rgb_pkg::rgb_pair_type rgb
);
   import pp2rgb_pkg::*;

   logic signed [SumW-1:0] r_l;
   logic signed [SumW-1:0] g_l;
   logic signed [SumW-1:0] b_l;
   logic signed [SumW-1:0] r_r;
   logic signed [SumW-1:0] g_r;
   logic signed [SumW-1:0] b_r;

   function automatic logic [ByteW-1:0] clamp_sum(input logic signed [SumW-1:0] s);
      if (s[SumW-1]) begin
         return '0;
      end else if (|s[SumW-2:FracW+ByteW]) begin
         return '1;
      end else begin
         return s[FracW+ByteW-1:FracW];
      end
   endfunction

   assign r_l = SumW'(products.luma_left) + SumW'(products.red_v);
   assign g_l = SumW'(products.luma_left) + SumW'(products.green_u) + SumW'(products.green_v);
   assign b_l = SumW'(products.luma_left) + SumW'(products.blue_u);
   assign r_r = SumW'(products.luma_right) + SumW'(products.red_v);
   assign g_r = SumW'(products.luma_right) + SumW'(products.green_u) + SumW'(products.green_v);
   assign b_r = SumW'(products.luma_right) + SumW'(products.blue_u);

   always_comb begin
      if (products.is_yuv) begin
         rgb.red_left    = clamp_sum(r_l);
         rgb.green_left  = clamp_sum(g_l);
         rgb.blue_left   = clamp_sum(b_l);
         rgb.red_right   = clamp_sum(r_r);
         rgb.green_right = clamp_sum(g_r);
         rgb.blue_right  = clamp_sum(b_r);
      end else begin
         rgb = products.direct;
      end
   end

endmodule

// ===== design/pixel_pair_to_rgb24_converter_top.sv =====
// pixel pair to rgb24 converter: top level with config registers and
// the three-register pipeline (input, products, result)
// depends on pp2rgb_pkg, pp2rgb_unpack, pp2rgb_yuv_mult, pp2rgb_mix
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  packed_bytes, chroma_first, chroma_second
//   rsp      out  rsp_valid/rsp_ready  red/green/blue, left and right
//   csr      in   csr_we               csr_index, csr_wdata
//
// one beat per cycle in and out while rsp_ready stays high
// the path is input register, multiplier level, products register, sums and
// clamp, result register
// reset clears the stage valids and loads bgr24, bt.709, limited range
// with rsp_ready low the result holds; req_ready drops once all three stages
// hold a beat
`timescale 1ns / 1ps

module pixel_pair_to_rgb24_converter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pp2rgb_pkg::WordW-1:0]    req_packed_bytes,
   input  logic [pp2rgb_pkg::ByteW-1:0]    req_chroma_first,
   input  logic [pp2rgb_pkg::ByteW-1:0]    req_chroma_second,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pp2rgb_pkg::ByteW-1:0]    rsp_red_left,
   output logic [pp2rgb_pkg::ByteW-1:0]    rsp_green_left,
   output logic [pp2rgb_pkg::ByteW-1:0]    rsp_blue_left,
   output logic [pp2rgb_pkg::ByteW-1:0]    rsp_red_right,
   output logic [pp2rgb_pkg::ByteW-1:0]    rsp_green_right,
   output logic [pp2rgb_pkg::ByteW-1:0]    rsp_blue_right,
   input  logic                            csr_we,
   input  logic [pp2rgb_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [pp2rgb_pkg::CsrDataW-1:0] csr_wdata
);
   import pp2rgb_pkg::*;

   csr_type          csr_ff;
   csr_type          csr_in;

   logic             s1_vld_ff;
   logic             s2_vld_ff;
   logic             out_vld_ff;
   logic             s1_adv;
   logic             s2_adv;
   logic             out_adv;
   logic [2:0]       vld_vec;

   logic [WordW-1:0] bytes_ff;
   logic [ByteW-1:0] c1_ff;
   logic [ByteW-1:0] c2_ff;
   unpack_type       unpacked;
   prod_type         prod_in;
   prod_type         prod_ff;
   rgb_pair_type     rgb_in;
   rgb_pair_type     rgb_ff;

   // config registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT:  csr_in.pixel_format  = csr_wdata;
            CSR_MATRIX_SELECT: csr_in.matrix_select = csr_wdata[0];
            CSR_FULL_RANGE:    csr_in.full_range    = csr_wdata[0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pixel_format  <= FMT_BGR24;
         csr_ff.matrix_select <= 1'b1;
         csr_ff.full_range    <= 1'b0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // pipeline flow control
   assign out_adv   = !out_vld_ff || rsp_ready;
   assign s2_adv    = !s2_vld_ff || out_adv;
   assign s1_adv    = !s1_vld_ff || s2_adv;
   assign req_ready = s1_adv;
   assign vld_vec   = {s1_vld_ff, s2_vld_ff, out_vld_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_adv) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (out_adv) begin
            out_vld_ff <= s2_vld_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_adv && req_valid) begin
         bytes_ff <= req_packed_bytes;
         c1_ff    <= req_chroma_first;
         c2_ff    <= req_chroma_second;
      end
      if (s2_adv && s1_vld_ff) begin
         prod_ff <= prod_in;
      end
      if (out_adv && s2_vld_ff) begin
         rgb_ff <= rgb_in;
      end
   end

   pp2rgb_unpack u_unpack (
      .packed_bytes  (bytes_ff),
      .chroma_first  (c1_ff),
      .chroma_second (c2_ff),
      .pixel_format  (csr_ff.pixel_format),
      .unpacked      (unpacked)
   );

   pp2rgb_yuv_mult u_yuv_mult (
      .unpacked      (unpacked),
      .matrix_select (csr_ff.matrix_select),
      .full_range    (csr_ff.full_range),
      .products      (prod_in)
   );

   pp2rgb_mix u_mix (
      .products (prod_ff),
      .rgb      (rgb_in)
   );

   assign rsp_valid       = out_vld_ff;
   assign rsp_red_left    = rgb_ff.red_left;
   assign rsp_green_left  = rgb_ff.green_left;
   assign rsp_blue_left   = rgb_ff.blue_left;
   assign rsp_red_right   = rgb_ff.red_right;
   assign rsp_green_right = rgb_ff.green_right;
   assign rsp_blue_right  = rgb_ff.blue_right;

   // nothing comes out in the cycle after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // back-pressure only when the whole pipe is full and stalled
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (vld_vec == 3'b111) && !rsp_ready)
      else $error("req_ready low with room in the pipeline");

   // beats in flight change only by accepts and deliveries
   a_beat_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (3'($countones(vld_vec)) ==
         3'($countones($past(vld_vec))) + 3'($past(req_valid && req_ready))
         - 3'($past(rsp_valid && rsp_ready))))
      else $error("beat lost or duplicated in pipeline");

endmodule

// ===== test/pixel_pair_to_rgb24_converter_checker.sv =====
// pixel pair to rgb24 converter: checker that tracks the config writes, predicts
// each rgb pair from the accepted request beats and compares the response beats
// depends on pp2rgb_pkg
`timescale 1ns / 1ps

module pixel_pair_to_rgb24_converter_checker
   import pp2rgb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [WordW-1:0]    req_packed_bytes,
   input  logic [ByteW-1:0]    req_chroma_first,
   input  logic [ByteW-1:0]    req_chroma_second,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [ByteW-1:0]    rsp_red_left,
   input  logic [ByteW-1:0]    rsp_green_left,
   input  logic [ByteW-1:0]    rsp_blue_left,
   input  logic [ByteW-1:0]    rsp_red_right,
   input  logic [ByteW-1:0]    rsp_green_right,
   input  logic [ByteW-1:0]    rsp_blue_right,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  pairs_outstanding,
   output int                  field_mismatches
);

   localparam int LimitedGain = 76284;
   localparam int Rv601       = 104595;
   localparam int Gu601       = 25690;
   localparam int Gv601       = 53281;
   localparam int Bu601       = 132186;
   localparam int Rv709       = 117506;
   localparam int Gu709       = 13959;
   localparam int Gv709       = 34931;
   localparam int Bu709       = 138412;

   logic [FmtW-1:0] fmt_q;
   logic            matrix_q;
   logic            full_range_q;
   rgb_pair_type    rgb_pairs_due [$];
   string           field_names [6] = '{"red_left", "green_left", "blue_left",
                                        "red_right", "green_right", "blue_right"};

   function automatic logic [7:0] clamp_byte(input int s);
      if (s < 0) return 8'd0;
      if ((s >>> 16) > 255) return 8'hff;
      return 8'(s >>> 16);
   endfunction

   function automatic logic [23:0] yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                              input logic [7:0] v);
      int luma, cu, cv;
      cu = int'(u) - 128;
      cv = int'(v) - 128;
      luma = full_range_q ? int'(y) * 65536 : (int'(y) - 16) * LimitedGain;
      if (matrix_q == MATRIX_BT601)
         return {clamp_byte(luma + Rv601 * cv),
                 clamp_byte(luma - Gu601 * cu - Gv601 * cv),
                 clamp_byte(luma + Bu601 * cu)};
      return {clamp_byte(luma + Rv709 * cv),
              clamp_byte(luma - Gu709 * cu - Gv709 * cv),
              clamp_byte(luma + Bu709 * cu)};
   endfunction

   function automatic logic [23:0] expand_565(input logic [15:0] pix);
      return {pix[15:11], 3'b111, pix[10:5], 2'b11, pix[4:0], 3'b111};
   endfunction

   function automatic rgb_pair_type predict_rgb_pair(input logic [WordW-1:0] w,
                                                     input logic [ByteW-1:0] c1,
                                                     input logic [ByteW-1:0] c2);
      logic [23:0] left, right;
      logic [7:0]  u, v;
      int          yo, uo;
      case (fmt_q)
         FMT_RGB565: begin
            left  = expand_565({w[7:0], w[15:8]});
            right = expand_565({w[23:16], w[31:24]});
         end
         FMT_RGB565X: begin
            left  = expand_565(w[15:0]);
            right = expand_565(w[31:16]);
         end
         FMT_YUYV, FMT_UYVY, FMT_YVYU, FMT_VYUY: begin
            yo    = (fmt_q == FMT_YUYV || fmt_q == FMT_YVYU) ? 0 : 1;
            uo    = (fmt_q == FMT_YUYV || fmt_q == FMT_UYVY) ? 0 : 2;
            u     = w[8*(1-yo+uo) +: 8];
            v     = w[8*(3-yo-uo) +: 8];
            left  = yuv_to_rgb(w[8*yo +: 8], u, v);
            right = yuv_to_rgb(w[8*(yo+2) +: 8], u, v);
         end
         FMT_SEMI_UV, FMT_PLANAR_UV: begin
            left  = yuv_to_rgb(w[7:0], c1, c2);
            right = yuv_to_rgb(w[15:8], c1, c2);
         end
         FMT_SEMI_VU, FMT_PLANAR_VU: begin
            left  = yuv_to_rgb(w[7:0], c2, c1);
            right = yuv_to_rgb(w[15:8], c2, c1);
         end
         FMT_XRGB32: begin
            left  = {w[15:8], w[23:16], w[31:24]};
            right = {w[47:40], w[55:48], w[63:56]};
         end
         FMT_XBGR32: begin
            left  = w[23:0];
            right = w[55:32];
         end
         default: begin
            left  = w[23:0];
            right = w[47:24];
         end
      endcase
      return {left, right};
   endfunction

   always @(posedge clock) begin : watch_beats
      rgb_pair_type seen, due;
      if (reset) begin
         fmt_q        = FMT_BGR24;
         matrix_q     = 1'b1;
         full_range_q = 1'b0;
         rgb_pairs_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_red_left, rsp_green_left, rsp_blue_left,
                    rsp_red_right, rsp_green_right, rsp_blue_right};
            if (rgb_pairs_due.size() == 0) begin
               $error("rsp beat with no pair due");
               field_mismatches++;
            end else begin
               due = rgb_pairs_due.pop_front();
               for (int i = 0; i < 6; i++)
                  if (seen[47-8*i -: 8] !== due[47-8*i -: 8]) begin
                     $error("%s: expected %0d, got %0d", field_names[i],
                            due[47-8*i -: 8], seen[47-8*i -: 8]);
                     field_mismatches++;
                  end
            end
         end
         if (req_valid && req_ready)
            rgb_pairs_due.push_back(predict_rgb_pair(req_packed_bytes, req_chroma_first,
                                                     req_chroma_second));
         if (csr_we)
            case (csr_index)
               CSR_PIXEL_FORMAT:  fmt_q = csr_wdata;
               CSR_MATRIX_SELECT: matrix_q = csr_wdata[0];
               CSR_FULL_RANGE:    full_range_q = csr_wdata[0];
               default: ;
            endcase
      end
      pairs_outstanding <= rgb_pairs_due.size();
   end

endmodule

// ===== test/pixel_pair_to_rgb24_converter_top_test.sv =====
// pixel pair to rgb24 converter: top of the test, drives config phases, corner
// and random pixel pairs with random idling, and reports the verdict
// depends on pp2rgb_pkg, pixel_pair_to_rgb24_converter_top and its checker
`timescale 1ns / 1ps

module pixel_pair_to_rgb24_converter_top_test;
   import pp2rgb_pkg::*;

   localparam logic [CsrIdxW-1:0] CsrSpareIdx = 2'd3;
   localparam int                 NumPhases   = 32;
   localparam int                 IdlePct     = 31;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [WordW-1:0]    req_packed_bytes = '0;
   logic [ByteW-1:0]    req_chroma_first = '0;
   logic [ByteW-1:0]    req_chroma_second = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ByteW-1:0]    rsp_red_left, rsp_green_left, rsp_blue_left;
   logic [ByteW-1:0]    rsp_red_right, rsp_green_right, rsp_blue_right;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;
   logic                steady = 1'b0;
   int                  pairs_outstanding;
   int                  field_mismatches;

   logic [WordW-1:0] corner_words [4] = '{64'h0, '1, 64'hff00_ff00_ff00_ff00,
                                          64'h00ff_00ff_00ff_00ff};
   logic [ByteW-1:0] corner_chroma [4] = '{8'h00, 8'hff, 8'h00, 8'hff};

   pixel_pair_to_rgb24_converter_top u_top (.*);

   pixel_pair_to_rgb24_converter_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= IdlePct);

   task automatic send_pair(input logic [WordW-1:0] w, input logic [ByteW-1:0] c1,
                            input logic [ByteW-1:0] c2);
      while (!steady && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_packed_bytes  <= w;
      req_chroma_first  <= c1;
      req_chroma_second <= c2;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pairs_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   initial begin
      logic [WordW-1:0] w;
      logic [3:0]       p4;
      int               items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: bgr24, bt.709, limited range
      for (int d = 0; d < 4; d++)
         send_pair(corner_words[d], corner_chroma[d], ~corner_chroma[d]);
      wait_drained();

      for (int p = 1; p <= NumPhases; p++) begin
         p4 = p[3:0];
         write_csr(CSR_PIXEL_FORMAT, p4);
         write_csr(CSR_MATRIX_SELECT, {3'($urandom), p[0] ^ p[4]});
         write_csr(CSR_FULL_RANGE, {3'($urandom), p[4]});
         if (p % 5 == 0)
            write_csr(CsrSpareIdx, 4'($urandom));
         csr_we <= 1'b0;
         steady <= (p >= 10 && p <= 13);
         @(posedge clock);

         // yuv corners: dark and bright luma against extreme chroma
         if (p4 >= FMT_YUYV && p4 <= FMT_PLANAR_VU)
            send_pair(corner_words[p % 4], corner_chroma[p % 4], ~corner_chroma[p % 4]);

         items = $urandom_range(54, 40);
         for (int n = 0; n < items; n++) begin
            w = {$urandom, $urandom};
            if ($urandom_range(7) == 0)
               for (int k = 0; k < NumBytes; k++)
                  case ($urandom_range(2))
                     0: w[8*k +: 8] = 8'h00;
                     1: w[8*k +: 8] = 8'hff;
                     default: ;
                  endcase
            if (p % 8 == 3 && n == items / 2)
               wait_drained();
            send_pair(w, 8'($urandom), 8'($urandom));
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (field_mismatches == 0)
         $display("pixel_pair_to_rgb24_converter_top: match");
      else
         $display("pixel_pair_to_rgb24_converter_top: mismatch");
      $finish;
   end

   initial begin
      #2ms;
      $display("pixel_pair_to_rgb24_converter_top: mismatch");
      $finish;
   end

endmodule

// ===== pixel_pair_to_rgb24_converter_top.f =====
design/pp2rgb_pkg.sv
design/pp2rgb_unpack.sv
design/pp2rgb_yuv_mult.sv
design/pp2rgb_mix.sv
design/pixel_pair_to_rgb24_converter_top.sv
test/pixel_pair_to_rgb24_converter_checker.sv
test/pixel_pair_to_rgb24_converter_top_test.sv
